### sv/lfcz_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfcz_pkg
// Shared types and constants for the rangefinder frame check and zone
// classifier: item layouts, zone codes, register map and reset values.
// ----------------------------------------------------------------------------
package lfcz_pkg;

    localparam int          FRAME_LEN   = 9;
    localparam logic [7:0]  HDR_BYTE    = 8'h59;
    localparam logic [15:0] CNT_SAT     = 16'hFFFF;

    // zone codes
    localparam logic [2:0] ZONE_CLEAR = 3'd0;
    localparam logic [2:0] ZONE_WARN  = 3'd1;
    localparam logic [2:0] ZONE_BRAKE = 3'd2;
    localparam logic [2:0] ZONE_EMERG = 3'd3;
    localparam logic [2:0] ZONE_FAULT = 3'd4;

    // register map, register i at byte address 4*i
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    typedef enum logic [2:0] {
        REG_EMERGENCY_LIMIT  = 3'd0,
        REG_BRAKE_LIMIT      = 3'd1,
        REG_WARN_LIMIT       = 3'd2,
        REG_RANGE_MINIMUM    = 3'd3,
        REG_RANGE_MAXIMUM    = 3'd4,
        REG_STRENGTH_MINIMUM = 3'd5,
        REG_TIMEOUT_TICKS    = 3'd6,
        REG_STUCK_READINGS   = 3'd7
    } reg_index_t;

    localparam logic [15:0] RST_EMERGENCY_LIMIT  = 16'd0;
    localparam logic [15:0] RST_BRAKE_LIMIT      = 16'd0;
    localparam logic [15:0] RST_WARN_LIMIT       = 16'd0;
    localparam logic [15:0] RST_RANGE_MINIMUM    = 16'd2;
    localparam logic [15:0] RST_RANGE_MAXIMUM    = 16'd1200;
    localparam logic [15:0] RST_STRENGTH_MINIMUM = 16'd100;
    localparam logic [15:0] RST_TIMEOUT_TICKS    = 16'd10;
    localparam logic [15:0] RST_STUCK_READINGS   = 16'd50;

    typedef struct packed {
        logic [3:0] bytes_received;
        logic [7:0] byte_0;
        logic [7:0] byte_1;
        logic [7:0] byte_2;
        logic [7:0] byte_3;
        logic [7:0] byte_4;
        logic [7:0] byte_5;
        logic [7:0] byte_6;
        logic [7:0] byte_7;
        logic [7:0] byte_8;
    } in_item_t;

    typedef struct packed {
        logic [15:0] distance_out;
        logic [15:0] strength_level;
        logic [2:0]  zone;
        logic        fault;
        logic        timeout_event;
        logic        checksum_event;
        logic        weak_signal_event;
        logic        stuck_event;
        logic        all_passed;
    } out_item_t;

endpackage
`default_nettype wire

### sv/lfcz_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfcz_in_if / lfcz_out_if
// Valid/ready channels for tick items in and classified results out.
// ----------------------------------------------------------------------------
interface lfcz_in_if;
    logic       valid;
    logic       ready;
    logic [3:0] bytes_received;
    logic [7:0] byte_0;
    logic [7:0] byte_1;
    logic [7:0] byte_2;
    logic [7:0] byte_3;
    logic [7:0] byte_4;
    logic [7:0] byte_5;
    logic [7:0] byte_6;
    logic [7:0] byte_7;
    logic [7:0] byte_8;

    modport source (
        output valid, bytes_received, byte_0, byte_1, byte_2, byte_3,
               byte_4, byte_5, byte_6, byte_7, byte_8,
        input  ready
    );
    modport sink (
        input  valid, bytes_received, byte_0, byte_1, byte_2, byte_3,
               byte_4, byte_5, byte_6, byte_7, byte_8,
        output ready
    );
endinterface

interface lfcz_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] distance_out;
    logic [15:0] strength_level;
    logic [2:0]  zone;
    logic        fault;
    logic        timeout_event;
    logic        checksum_event;
    logic        weak_signal_event;
    logic        stuck_event;
    logic        all_passed;

    modport source (
        output valid, distance_out, strength_level, zone, fault, timeout_event,
               checksum_event, weak_signal_event, stuck_event, all_passed,
        input  ready
    );
    modport sink (
        input  valid, distance_out, strength_level, zone, fault, timeout_event,
               checksum_event, weak_signal_event, stuck_event, all_passed,
        output ready
    );
endinterface
`default_nettype wire

### sv/lidar_frame_check_zone_classifier_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_frame_check_zone_classifier_unit
// Validates one rangefinder frame per tick, tracks timeout and stuck
// readings, and classifies the held distance into a zone.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    bytes_received, byte_0 .. byte_8
//  out_ch    out  valid/ready    distance_out, strength_level, zone, flags
//  apb       in   psel/penable   8 x 16-bit registers at 4*i
//
//  One tick item per clock while the result side is not stalled. An item
//  sits in the input register while frame check, counters and zoning
//  resolve into the result register, from which out_ch valid is driven.
//  Tracking state updates when an item moves from input to result register.
//  A stalled result holds both registers; the input side keeps taking items
//  while the result register drains. rst_n clears control and tracking
//  state and loads register reset values; no clearing pass.
// ----------------------------------------------------------------------------
module lidar_frame_check_zone_classifier_unit
    import lfcz_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    lfcz_in_if.sink                    in_ch,
    lfcz_out_if.source                 out_ch,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    // configuration
    logic [15:0] emergency_limit_reg;
    logic [15:0] brake_limit_reg;
    logic [15:0] warn_limit_reg;
    logic [15:0] range_minimum_reg;
    logic [15:0] range_maximum_reg;
    logic [15:0] strength_minimum_reg;
    logic [15:0] timeout_ticks_reg;
    logic [15:0] stuck_readings_reg;

    reg_index_t  reg_sel;
    logic        cfg_write;

    // pipeline
    logic        s1_valid_reg;
    in_item_t    s1_item_reg;
    logic        out_valid_reg;
    out_item_t   out_item_reg;
    logic        s1_go;
    in_item_t    in_item;

    // tracking state
    logic [15:0] miss_reg,      miss_next;
    logic [15:0] last_reg,      last_next;
    logic [15:0] repeat_reg,    repeat_next;
    logic [15:0] held_dist_reg, held_dist_next;
    logic [15:0] held_str_reg,  held_str_next;
    logic [2:0]  held_zone_reg, held_zone_next;
    out_item_t   result;

    assign pready    = 1'b1;
    assign reg_sel   = reg_index_t'(paddr[APB_ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emergency_limit_reg  <= RST_EMERGENCY_LIMIT;
            brake_limit_reg      <= RST_BRAKE_LIMIT;
            warn_limit_reg       <= RST_WARN_LIMIT;
            range_minimum_reg    <= RST_RANGE_MINIMUM;
            range_maximum_reg    <= RST_RANGE_MAXIMUM;
            strength_minimum_reg <= RST_STRENGTH_MINIMUM;
            timeout_ticks_reg    <= RST_TIMEOUT_TICKS;
            stuck_readings_reg   <= RST_STUCK_READINGS;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_EMERGENCY_LIMIT:  emergency_limit_reg  <= pwdata[15:0];
                REG_BRAKE_LIMIT:      brake_limit_reg      <= pwdata[15:0];
                REG_WARN_LIMIT:       warn_limit_reg       <= pwdata[15:0];
                REG_RANGE_MINIMUM:    range_minimum_reg    <= pwdata[15:0];
                REG_RANGE_MAXIMUM:    range_maximum_reg    <= pwdata[15:0];
                REG_STRENGTH_MINIMUM: strength_minimum_reg <= pwdata[15:0];
                REG_TIMEOUT_TICKS:    timeout_ticks_reg    <= pwdata[15:0];
                REG_STUCK_READINGS:   stuck_readings_reg   <= pwdata[15:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_sel)
            REG_EMERGENCY_LIMIT:  prdata[15:0] = emergency_limit_reg;
            REG_BRAKE_LIMIT:      prdata[15:0] = brake_limit_reg;
            REG_WARN_LIMIT:       prdata[15:0] = warn_limit_reg;
            REG_RANGE_MINIMUM:    prdata[15:0] = range_minimum_reg;
            REG_RANGE_MAXIMUM:    prdata[15:0] = range_maximum_reg;
            REG_STRENGTH_MINIMUM: prdata[15:0] = strength_minimum_reg;
            REG_TIMEOUT_TICKS:    prdata[15:0] = timeout_ticks_reg;
            REG_STUCK_READINGS:   prdata[15:0] = stuck_readings_reg;
            default:              prdata = '0;
        endcase
    end

    // handshake: advance stage 1 when the result register is free or draining
    assign s1_go       = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || s1_go;

    assign in_item.bytes_received = in_ch.bytes_received;
    assign in_item.byte_0         = in_ch.byte_0;
    assign in_item.byte_1         = in_ch.byte_1;
    assign in_item.byte_2         = in_ch.byte_2;
    assign in_item.byte_3         = in_ch.byte_3;
    assign in_item.byte_4         = in_ch.byte_4;
    assign in_item.byte_5         = in_ch.byte_5;
    assign in_item.byte_6         = in_ch.byte_6;
    assign in_item.byte_7         = in_ch.byte_7;
    assign in_item.byte_8         = in_ch.byte_8;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                s1_valid_reg <= in_ch.valid;
            end
            if (s1_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            s1_item_reg <= in_item;
        end
        if (s1_go)
        begin
            out_item_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            miss_reg      <= '0;
            last_reg      <= '0;
            repeat_reg    <= '0;
            held_dist_reg <= '0;
            held_str_reg  <= '0;
            held_zone_reg <= ZONE_FAULT;
        end
        else if (s1_go)
        begin
            miss_reg      <= miss_next;
            last_reg      <= last_next;
            repeat_reg    <= repeat_next;
            held_dist_reg <= held_dist_next;
            held_str_reg  <= held_str_next;
            held_zone_reg <= held_zone_next;
        end
    end

    // frame check, fault ladder and zoning
    always_comb
    begin
        logic [7:0]  sum;
        logic        hdr_ok;
        logic        frame;
        logic        ev_sum;
        logic        ev_timeout;
        logic        ev_weak;
        logic        ev_stuck;
        logic        fault;
        logic        plaus_fault;
        logic [15:0] reading;
        logic [15:0] str;
        logic [15:0] miss_inc;
        logic [15:0] rep_inc;
        logic [15:0] thr;
        logic [2:0]  zone_cls;

        sum = s1_item_reg.byte_0 + s1_item_reg.byte_1 + s1_item_reg.byte_2
            + s1_item_reg.byte_3 + s1_item_reg.byte_4 + s1_item_reg.byte_5
            + s1_item_reg.byte_6 + s1_item_reg.byte_7;
        hdr_ok = (s1_item_reg.bytes_received >= 4'(FRAME_LEN))
              && (s1_item_reg.byte_0 == HDR_BYTE)
              && (s1_item_reg.byte_1 == HDR_BYTE);
        frame   = hdr_ok && (sum == s1_item_reg.byte_8);
        ev_sum  = hdr_ok && (sum != s1_item_reg.byte_8);
        reading = {s1_item_reg.byte_3, s1_item_reg.byte_2};
        str     = {s1_item_reg.byte_5, s1_item_reg.byte_4};

        // saturating miss count, clamped at the timeout
        miss_inc = (miss_reg == CNT_SAT) ? miss_reg : miss_reg + 16'd1;
        miss_next = frame ? 16'd0 : miss_inc;
        ev_timeout = (miss_next >= timeout_ticks_reg);
        if (ev_timeout)
        begin
            miss_next = timeout_ticks_reg;
        end
        fault = ev_timeout || ev_sum;

        plaus_fault = (reading < range_minimum_reg) || (reading > range_maximum_reg);
        ev_weak     = frame && !fault && (str < strength_minimum_reg);

        rep_inc  = (repeat_reg == CNT_SAT) ? repeat_reg : repeat_reg + 16'd1;
        thr      = stuck_readings_reg - 16'd1;
        ev_stuck    = 1'b0;
        last_next   = last_reg;
        repeat_next = repeat_reg;
        if (frame && !fault)
        begin
            if (plaus_fault || ev_weak)
            begin
                fault = 1'b1;
            end
            else
            begin
                // track repeats only for readings that pass every check
                if (reading == last_reg)
                begin
                    repeat_next = rep_inc;
                    ev_stuck    = (rep_inc >= thr);
                end
                else
                begin
                    repeat_next = '0;
                end
                last_next = reading;
                fault     = ev_stuck;
            end
        end

        priority if (reading <= emergency_limit_reg)
            zone_cls = ZONE_EMERG;
        else if (reading <= brake_limit_reg)
            zone_cls = ZONE_BRAKE;
        else if (reading <= warn_limit_reg)
            zone_cls = ZONE_WARN;
        else
            zone_cls = ZONE_CLEAR;

        held_dist_next = held_dist_reg;
        held_str_next  = held_str_reg;
        held_zone_next = held_zone_reg;
        if (fault)
        begin
            held_dist_next = '0;
            held_str_next  = '0;
            held_zone_next = ZONE_FAULT;
        end
        else if (frame)
        begin
            held_dist_next = reading;
            held_str_next  = str;
            held_zone_next = zone_cls;
        end

        result.distance_out      = held_dist_next;
        result.strength_level    = held_str_next;
        result.zone              = held_zone_next;
        result.fault             = fault;
        result.timeout_event     = ev_timeout;
        result.checksum_event    = ev_sum;
        result.weak_signal_event = ev_weak;
        result.stuck_event       = ev_stuck;
        result.all_passed        = frame && !fault;
    end

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.distance_out      = out_item_reg.distance_out;
    assign out_ch.strength_level    = out_item_reg.strength_level;
    assign out_ch.zone              = out_item_reg.zone;
    assign out_ch.fault             = out_item_reg.fault;
    assign out_ch.timeout_event     = out_item_reg.timeout_event;
    assign out_ch.checksum_event    = out_item_reg.checksum_event;
    assign out_ch.weak_signal_event = out_item_reg.weak_signal_event;
    assign out_ch.stuck_event       = out_item_reg.stuck_event;
    assign out_ch.all_passed        = out_item_reg.all_passed;

endmodule
`default_nettype wire

### sim/lfcz_zone_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfcz_zone_checker
// Watches the tick and result channels and the register port of the frame
// check and zone classifier. Predicts each result from the accepted tick and
// its own copy of the registers and tracking state, then compares it field by
// field with the result that comes out.
// ----------------------------------------------------------------------------
module lfcz_zone_checker
    import lfcz_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    lfcz_in_if                         tick_ch,
    lfcz_out_if                        result_ch,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic                  pready,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output int unsigned                mismatches,
    output int unsigned                outstanding
);

    logic [15:0] lim [8];
    logic [15:0] miss_cnt;
    logic [15:0] last_dist;
    logic [15:0] repeat_cnt;
    logic [15:0] hold_dist;
    logic [15:0] hold_str;
    logic [2:0]  hold_zone;

    out_item_t expected_results [$];

    function automatic out_item_t classify_tick(in_item_t t);
        out_item_t   r;
        logic [7:0]  csum;
        logic [15:0] d;
        logic [15:0] s;
        logic [15:0] stuck_thr;
        logic        good;
        logic        bad;
        r = '0;
        good = 1'b0;
        bad = 1'b0;
        d = {t.byte_3, t.byte_2};
        s = {t.byte_5, t.byte_4};
        if (t.bytes_received >= FRAME_LEN && t.byte_0 == HDR_BYTE && t.byte_1 == HDR_BYTE)
        begin
            csum = t.byte_0 + t.byte_1 + t.byte_2 + t.byte_3
                 + t.byte_4 + t.byte_5 + t.byte_6 + t.byte_7;
            if (csum == t.byte_8)
                good = 1'b1;
            else
                r.checksum_event = 1'b1;
        end
        if (good)
            miss_cnt = '0;
        else
        begin
            if (miss_cnt != CNT_SAT)
                miss_cnt++;
            if (r.checksum_event)
                bad = 1'b1;
        end
        // clamp the miss count so the fault repeats every tick until a frame
        if (miss_cnt >= lim[REG_TIMEOUT_TICKS])
        begin
            bad = 1'b1;
            r.timeout_event = 1'b1;
            miss_cnt = lim[REG_TIMEOUT_TICKS];
        end
        if (good && !bad)
        begin
            if (d < lim[REG_RANGE_MINIMUM] || d > lim[REG_RANGE_MAXIMUM])
                bad = 1'b1;
            if (s < lim[REG_STRENGTH_MINIMUM])
            begin
                bad = 1'b1;
                r.weak_signal_event = 1'b1;
            end
            // stuck tracking only advances on an otherwise clean reading
            if (!bad)
            begin
                if (d == last_dist)
                begin
                    stuck_thr = lim[REG_STUCK_READINGS] - 16'd1;
                    if (repeat_cnt != CNT_SAT)
                        repeat_cnt++;
                    if (repeat_cnt >= stuck_thr)
                    begin
                        bad = 1'b1;
                        r.stuck_event = 1'b1;
                    end
                end
                else
                    repeat_cnt = '0;
                last_dist = d;
            end
        end
        if (bad)
        begin
            hold_dist = '0;
            hold_str = '0;
            hold_zone = ZONE_FAULT;
        end
        else if (good)
        begin
            hold_dist = d;
            hold_str = s;
            if (d <= lim[REG_EMERGENCY_LIMIT])
                hold_zone = ZONE_EMERG;
            else if (d <= lim[REG_BRAKE_LIMIT])
                hold_zone = ZONE_BRAKE;
            else if (d <= lim[REG_WARN_LIMIT])
                hold_zone = ZONE_WARN;
            else
                hold_zone = ZONE_CLEAR;
        end
        r.distance_out = hold_dist;
        r.strength_level = hold_str;
        r.zone = hold_zone;
        r.fault = bad;
        r.all_passed = good && !bad;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        in_item_t  tick;
        out_item_t want;
        out_item_t got;
        if (!rst_n)
        begin
            lim[REG_EMERGENCY_LIMIT]  = RST_EMERGENCY_LIMIT;
            lim[REG_BRAKE_LIMIT]      = RST_BRAKE_LIMIT;
            lim[REG_WARN_LIMIT]       = RST_WARN_LIMIT;
            lim[REG_RANGE_MINIMUM]    = RST_RANGE_MINIMUM;
            lim[REG_RANGE_MAXIMUM]    = RST_RANGE_MAXIMUM;
            lim[REG_STRENGTH_MINIMUM] = RST_STRENGTH_MINIMUM;
            lim[REG_TIMEOUT_TICKS]    = RST_TIMEOUT_TICKS;
            lim[REG_STUCK_READINGS]   = RST_STUCK_READINGS;
            miss_cnt = '0;
            last_dist = '0;
            repeat_cnt = '0;
            hold_dist = '0;
            hold_str = '0;
            hold_zone = ZONE_FAULT;
            expected_results.delete();
            mismatches = 0;
        end
        else
        begin
            // retire the oldest expectation before queuing a new one
            if (result_ch.valid && result_ch.ready)
            begin
                got = {result_ch.distance_out, result_ch.strength_level, result_ch.zone,
                       result_ch.fault, result_ch.timeout_event, result_ch.checksum_event,
                       result_ch.weak_signal_event, result_ch.stuck_event,
                       result_ch.all_passed};
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with no expected result pending");
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("distance_out", want.distance_out, got.distance_out);
                    check_field("strength_level", want.strength_level, got.strength_level);
                    check_field("zone", want.zone, got.zone);
                    check_field("fault", want.fault, got.fault);
                    check_field("timeout_event", want.timeout_event, got.timeout_event);
                    check_field("checksum_event", want.checksum_event, got.checksum_event);
                    check_field("weak_signal_event", want.weak_signal_event,
                                got.weak_signal_event);
                    check_field("stuck_event", want.stuck_event, got.stuck_event);
                    check_field("all_passed", want.all_passed, got.all_passed);
                end
            end
            if (tick_ch.valid && tick_ch.ready)
            begin
                tick = {tick_ch.bytes_received, tick_ch.byte_0, tick_ch.byte_1,
                        tick_ch.byte_2, tick_ch.byte_3, tick_ch.byte_4, tick_ch.byte_5,
                        tick_ch.byte_6, tick_ch.byte_7, tick_ch.byte_8};
                expected_results.push_back(classify_tick(tick));
            end
            if (psel && penable && pwrite && pready)
                lim[paddr[APB_ADDR_W-1:2]] = pwdata[15:0];
        end
        outstanding = expected_results.size();
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives tick items and register writes into the frame check and zone
// classifier: a directed run over field extremes and special cases, then
// random phases under several register settings and idle profiles, with one
// long result stall. The checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module tb_top;
    import lfcz_pkg::*;

    localparam int unsigned ITEMS_PER_PHASE = 308;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int unsigned           fail_count;
    int unsigned           outstanding;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    logic        stall_req;
    logic [15:0] cfg_now [8];
    logic [15:0] run_dist;
    int unsigned run_left;
    int unsigned miss_left;

    lfcz_in_if  tick_bus ();
    lfcz_out_if result_bus ();

    lidar_frame_check_zone_classifier_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (tick_bus),
        .out_ch  (result_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    lfcz_zone_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick_ch     (tick_bus),
        .result_ch   (result_bus),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .mismatches  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic in_item_t make_frame(logic [3:0] n, logic [15:0] d, logic [15:0] s,
                                            logic [7:0] x6, logic [7:0] x7);
        in_item_t t;
        t.bytes_received = n;
        t.byte_0 = HDR_BYTE;
        t.byte_1 = HDR_BYTE;
        t.byte_2 = d[7:0];
        t.byte_3 = d[15:8];
        t.byte_4 = s[7:0];
        t.byte_5 = s[15:8];
        t.byte_6 = x6;
        t.byte_7 = x7;
        t.byte_8 = t.byte_0 + t.byte_1 + t.byte_2 + t.byte_3
                 + t.byte_4 + t.byte_5 + t.byte_6 + t.byte_7;
        return t;
    endfunction

    // Mostly well-formed frames with distances near the limits and runs of
    // repeats for stuck detection; bursts of misses to reach the timeout.
    function automatic in_item_t random_tick();
        in_item_t    t;
        logic [15:0] d;
        logic [15:0] s;
        logic [95:0] noise;
        int unsigned kind;
        if (run_left != 0)
        begin
            run_left--;
            d = run_dist;
        end
        else
        begin
            case ($urandom_range(5))
                0: d = cfg_now[REG_RANGE_MINIMUM] + 16'($urandom_range(2)) - 16'd1;
                1: d = cfg_now[REG_RANGE_MAXIMUM] + 16'($urandom_range(2)) - 16'd1;
                2: d = cfg_now[$urandom_range(2)] + 16'($urandom_range(2)) - 16'd1;
                3: d = 16'($urandom_range(1500));
                default: d = 16'($urandom);
            endcase
            run_dist = d;
            if ($urandom_range(7) == 0)
                run_left = ($urandom_range(4) == 0) ? $urandom_range(20, 70)
                                                    : $urandom_range(1, 8);
        end
        case ($urandom_range(3))
            0: s = cfg_now[REG_STRENGTH_MINIMUM];
            1: s = cfg_now[REG_STRENGTH_MINIMUM] - 16'd1;
            2: s = 16'($urandom);
            default: s = cfg_now[REG_STRENGTH_MINIMUM] + 16'($urandom_range(2000));
        endcase
        t = make_frame(4'd9, d, s, 8'($urandom), 8'($urandom));
        if (miss_left != 0)
        begin
            miss_left--;
            kind = $urandom_range(23);
        end
        else
        begin
            kind = $urandom_range(99);
            if ($urandom_range(39) == 0)
                miss_left = $urandom_range(2, 24);
        end
        if (kind < 8)
            t.bytes_received = 4'($urandom_range(8));
        else if (kind < 16)
        begin
            if ($urandom_range(1) == 0)
                t.byte_0 = 8'($urandom);
            else
                t.byte_1 = 8'($urandom);
        end
        else if (kind < 24)
            t.byte_8 = t.byte_8 ^ 8'($urandom_range(1, 255));
        else if (kind < 32)
            t.bytes_received = 4'($urandom_range(10, 15));
        else if (kind < 36)
        begin
            noise = {$urandom, $urandom, $urandom};
            t = noise[$bits(in_item_t)-1:0];
        end
        return t;
    endfunction

    // Call at a rising edge; returns at the edge of the transfer.
    task automatic push_tick(input in_item_t t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            tick_bus.valid <= 1'b0;
            @(posedge clk);
        end
        tick_bus.valid          <= 1'b1;
        tick_bus.bytes_received <= t.bytes_received;
        tick_bus.byte_0         <= t.byte_0;
        tick_bus.byte_1         <= t.byte_1;
        tick_bus.byte_2         <= t.byte_2;
        tick_bus.byte_3         <= t.byte_3;
        tick_bus.byte_4         <= t.byte_4;
        tick_bus.byte_5         <= t.byte_5;
        tick_bus.byte_6         <= t.byte_6;
        tick_bus.byte_7         <= t.byte_7;
        tick_bus.byte_8         <= t.byte_8;
        // ready is settled by the falling edge
        @(negedge clk);
        while (!tick_bus.ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic wait_results_drained();
        tick_bus.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input reg_index_t idx, input logic [15:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        cfg_now[idx] = v;
    endtask

    task automatic set_limits(input logic [15:0] emerg, brake, warn, rmin, rmax, smin,
                              tmo, stuck);
        apb_write(REG_EMERGENCY_LIMIT, emerg);
        apb_write(REG_BRAKE_LIMIT, brake);
        apb_write(REG_WARN_LIMIT, warn);
        apb_write(REG_RANGE_MINIMUM, rmin);
        apb_write(REG_RANGE_MAXIMUM, rmax);
        apb_write(REG_STRENGTH_MINIMUM, smin);
        apb_write(REG_TIMEOUT_TICKS, tmo);
        apb_write(REG_STUCK_READINGS, stuck);
    endtask

    initial
    begin : result_drain
        int unsigned hold_left;
        hold_left = 0;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_req)
            begin
                stall_req = 1'b0;
                hold_left = 400;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin : stimulus
        in_item_t    t;
        int unsigned total;
        send_idle_pct = 20;
        recv_idle_pct = 82;
        stall_req = 1'b0;
        run_left = 0;
        miss_left = 0;
        run_dist = '0;
        total = 0;
        rst_n   <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        tick_bus.valid <= 1'b0;
        tick_bus.bytes_received <= '0;
        tick_bus.byte_0 <= '0;
        tick_bus.byte_1 <= '0;
        tick_bus.byte_2 <= '0;
        tick_bus.byte_3 <= '0;
        tick_bus.byte_4 <= '0;
        tick_bus.byte_5 <= '0;
        tick_bus.byte_6 <= '0;
        tick_bus.byte_7 <= '0;
        tick_bus.byte_8 <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values: failed receive first, so the held fault shows
        t = '1;
        t.bytes_received = 4'd0;
        push_tick(t);
        push_tick(make_frame(4'd9, 16'd500, 16'd300, 8'hFF, 8'h00));
        push_tick(make_frame(4'd15, 16'd2, 16'd100, 8'h00, 8'hFF));
        push_tick(make_frame(4'd9, 16'd1200, 16'hFFFF, 8'h12, 8'h34));
        push_tick(make_frame(4'd9, 16'd1, 16'd300, 8'h00, 8'h00));
        push_tick(make_frame(4'd9, 16'd1201, 16'd300, 8'h00, 8'h00));
        push_tick(make_frame(4'd9, 16'd700, 16'd99, 8'h00, 8'h00));
        t = make_frame(4'd9, 16'd600, 16'd300, 8'hA5, 8'h5A);
        t.byte_8 = t.byte_8 ^ 8'h01;
        push_tick(t);
        t = make_frame(4'd9, 16'd600, 16'd300, 8'h00, 8'h00);
        t.byte_0 = 8'h58;
        push_tick(t);
        t = make_frame(4'd9, 16'd600, 16'd300, 8'h00, 8'h00);
        t.byte_1 = 8'hD9;
        push_tick(t);
        push_tick(make_frame(4'd8, 16'd600, 16'd300, 8'h00, 8'h00));
        push_tick(make_frame(4'd9, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF));
        push_tick('0);
        wait_results_drained();

        // zone boundaries, short timeout, then a stuck run
        set_limits(16'd100, 16'd200, 16'd300, 16'd0, 16'hFFFF, 16'd0, 16'd2, 16'd3);
        push_tick(make_frame(4'd9, 16'd100, 16'd500, 8'h00, 8'h00));
        push_tick(make_frame(4'd9, 16'd101, 16'd500, 8'h00, 8'h00));
        push_tick(make_frame(4'd9, 16'd200, 16'd500, 8'h00, 8'h00));
        push_tick(make_frame(4'd9, 16'd201, 16'd500, 8'h00, 8'h00));
        push_tick(make_frame(4'd9, 16'd300, 16'd500, 8'h00, 8'h00));
        push_tick(make_frame(4'd9, 16'd301, 16'd500, 8'h00, 8'h00));
        t = make_frame(4'd9, 16'd50, 16'd500, 8'h00, 8'h00);
        t.byte_0 = 8'h00;
        push_tick(t);
        push_tick(make_frame(4'd3, 16'd50, 16'd500, 8'h00, 8'h00));
        t = make_frame(4'd9, 16'd50, 16'd500, 8'h00, 8'h00);
        t.byte_8 = ~t.byte_8;
        push_tick(t);
        repeat (3) push_tick(make_frame(4'd9, 16'd50, 16'd500, 8'h00, 8'h00));
        wait_results_drained();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: set_limits(16'd50, 16'd150, 16'd400, 16'd2, 16'd1200, 16'd100,
                              16'd10, 16'd5);
                1: set_limits(16'd0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd1, 16'd1);
                2: set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              16'hFFFF, 16'hFFFF);
                3: set_limits(16'd300, 16'd200, 16'd100, 16'd100, 16'd900, 16'd500,
                              16'd0, 16'd0);
                4: set_limits(16'($urandom_range(1500)), 16'($urandom_range(1500)),
                              16'($urandom_range(1500)), 16'($urandom_range(300)),
                              16'($urandom_range(300, 65535)), 16'($urandom_range(2000)),
                              16'($urandom_range(1, 16)), 16'($urandom_range(1, 8)));
                default: set_limits(16'd20, 16'd80, 16'd200, 16'd10, 16'd700, 16'd50,
                                    16'd3, 16'd2);
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (total < 617)
                begin
                    send_idle_pct = 20;
                    recv_idle_pct = 82;
                end
                else if (total < 1234)
                begin
                    send_idle_pct = 82;
                    recv_idle_pct = 20;
                end
                else
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                // long result stall while ticks keep coming: fill and back up
                if (phase == 4 && n == 50)
                    stall_req = 1'b1;
                push_tick(random_tick());
                total++;
            end
            wait_results_drained();
        end

        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
